/* hdl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define WDST_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("wdst assertion failed");

// Checked on every clock edge, reset included.
`define WDST_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("wdst assertion failed");

`endif

/* hdl/wdst_pkg.sv */
// ----------------------------------------------------------------------------
// wdst_pkg
// Types and constants of the weighted decision stump trainer.
// ----------------------------------------------------------------------------
package wdst_pkg;

   localparam int FEAT_W = 32;
   localparam int WGT_W  = 16;
   localparam int SPLIT_W = 33;
   localparam int ERR_W  = 26;
   localparam logic [ERR_W-1:0] ERR_MAX = '1;

   typedef struct packed {
      logic                     valid;
      logic                     label;
      logic [WGT_W-1:0]         weight;
      logic signed [FEAT_W-1:0] feature;
   } sample_type;

   typedef enum logic [5:0] {
      S_LOAD   = 6'b000001,
      S_SETTLE = 6'b000010,
      S_DRAIN  = 6'b000100,
      S_FINAL  = 6'b001000,
      S_FLUSH  = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

endpackage

/* hdl/wdst_cell.sv */
// ----------------------------------------------------------------------------
// wdst_cell
// One cell of the sorting chain: keeps the smaller sample, passes the larger
// one right; in shift mode takes the right neighbor's sample.
// ----------------------------------------------------------------------------
module wdst_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift,
   input  wdst_pkg::sample_type   ins,
   input  wdst_pkg::sample_type   right,
   output wdst_pkg::sample_type   hold,
   output wdst_pkg::sample_type   pass
);
   import wdst_pkg::*;

   sample_type hold_ff, hold_in;
   sample_type pass_ff, pass_in;

   always_comb begin
      hold_in = hold_ff;
      pass_in = '0;
      if (shift) begin
         hold_in = right;
      end else if (ins.valid) begin
         if (!hold_ff.valid) begin
            hold_in = ins;
         end else if (ins.feature < hold_ff.feature) begin
            hold_in = ins;
            pass_in = hold_ff;
         end else begin
            pass_in = ins;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
         pass_ff <= '0;
      end else begin
         hold_ff <= hold_in;
         pass_ff <= pass_in;
      end
   end

   assign hold = hold_ff;
   assign pass = pass_ff;

endmodule

/* hdl/weighted_decision_stump_trainer.sv */
// ----------------------------------------------------------------------------
// weighted_decision_stump_trainer
// Trains a one-split weighted decision stump on a streamed sample set.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the trainer is in its load state,
// and ripple into a chain of MAX_SAMPLES sorting cells, so the chain holds
// them in ascending feature order. The beat with last_sample starts
// training: the chain is left to settle in the settle state, then shifts
// out one sample per cycle while the split scan runs, and after the final,
// flush and done states the result beat is posted. New samples are taken
// as soon as the result sits in the output register.
module weighted_decision_stump_trainer #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic signed [31:0]  csr_target_threshold,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_feature_value,
   input  logic signed [31:0]  req_target_value,
   input  logic [15:0]         req_sample_weight,
   input  logic                req_last_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [32:0]  rsp_split_twice,
   output logic                rsp_above_result,
   output logic                rsp_below_result,
   output logic [25:0]         rsp_weighted_error,
   output logic                rsp_no_split,
   output logic                rsp_overflow
);
   import wdst_pkg::*;

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int SW = WGT_W + CW;

   // configuration
   logic signed [31:0] thresh_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) thresh_ff <= '0;
      else if (csr_valid) thresh_ff <= csr_target_threshold;
   end

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, cnt_ff, cnt_in;
   logic ovf_ff, ovf_in;
   logic [SW-1:0] tot_t_ff, tot_t_in, tot_f_ff, tot_f_in;

   logic accept, store, shift;
   sample_type in_sample;
   sample_type hold_w [MAX_SAMPLES];
   sample_type pass_w [MAX_SAMPLES];

   assign req_ready = (state_ff == S_LOAD);
   assign accept    = req_valid && req_ready;
   assign store     = accept && (count_ff < CW'(MAX_SAMPLES));
   assign shift     = (state_ff == S_DRAIN);

   always_comb begin
      in_sample.valid   = store;
      in_sample.label   = req_target_value > thresh_ff;
      in_sample.weight  = req_sample_weight;
      in_sample.feature = req_feature_value;
   end

   for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
      sample_type ins_w, right_w;
      if (i == 0) begin : g_first
         assign ins_w = in_sample;
      end else begin : g_mid
         assign ins_w = pass_w[i-1];
      end
      if (i == MAX_SAMPLES - 1) begin : g_end
         assign right_w = '0;
      end else begin : g_inner
         assign right_w = hold_w[i+1];
      end
      wdst_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .ins   (ins_w),
         .right (right_w),
         .hold  (hold_w[i]),
         .pass  (pass_w[i])
      );
   end

   // scan state
   sample_type e;
   logic signed [31:0] pf_ff, pf_in;
   logic gdup_ff, gdup_in;
   logic [SW-1:0] bt_ff, bt_in, bf_ff, bf_in;
   logic signed [32:0] single_ff, single_in;
   // candidate stage
   logic cand_v_ff, cand_v_in;
   logic signed [32:0] cand_s_ff, cand_s_in;
   logic [SW-1:0] cand_bt_ff, cand_bt_in, cand_bf_ff, cand_bf_in;
   // error stage
   logic ev_v_ff;
   logic signed [32:0] ev_s_ff;
   logic [SW-1:0] ev_err_ff, ev_err_in, ab_t, ab_f;
   logic ev_a_ff, ev_a_in, ev_b_ff, ev_b_in;
   // best
   logic best_v_ff, best_v_in;
   logic signed [32:0] best_s_ff, best_s_in;
   logic [SW-1:0] best_err_ff, best_err_in;
   logic best_a_ff, best_a_in, best_b_ff, best_b_in;
   // output register
   logic rv_ff, rv_in;
   logic signed [32:0] o_s_ff, o_s_in;
   logic o_a_ff, o_a_in, o_b_ff, o_b_in, o_ns_ff, o_ns_in, o_ov_ff, o_ov_in;
   logic [ERR_W-1:0] o_e_ff, o_e_in;
   logic [SW+ERR_W-1:0] err_wide;

   assign e = hold_w[0];

   always_comb begin
      ab_t = tot_t_ff - cand_bt_ff;
      ab_f = tot_f_ff - cand_bf_ff;
      ev_a_in = ab_t > ab_f;
      ev_b_in = !(cand_bf_ff > cand_bt_ff);
      ev_err_in = (ev_a_in ? ab_f : ab_t) + (ev_b_in ? cand_bf_ff : cand_bt_ff);
      err_wide = {{ERR_W{1'b0}}, best_err_ff};
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      tot_t_in = tot_t_ff;
      tot_f_in = tot_f_ff;
      pf_in    = pf_ff;
      gdup_in  = gdup_ff;
      bt_in    = bt_ff;
      bf_in    = bf_ff;
      single_in = single_ff;
      cand_v_in  = 1'b0;
      cand_s_in  = cand_s_ff;
      cand_bt_in = bt_ff;
      cand_bf_in = bf_ff;
      best_v_in   = best_v_ff;
      best_s_in   = best_s_ff;
      best_err_in = best_err_ff;
      best_a_in   = best_a_ff;
      best_b_in   = best_b_ff;
      rv_in   = rv_ff && !rsp_ready;
      o_s_in  = o_s_ff;
      o_a_in  = o_a_ff;
      o_b_in  = o_b_ff;
      o_e_in  = o_e_ff;
      o_ns_in = o_ns_ff;
      o_ov_in = o_ov_ff;

      if (ev_v_ff && (!best_v_ff || ev_err_ff < best_err_ff)) begin
         best_v_in   = 1'b1;
         best_s_in   = ev_s_ff;
         best_err_in = ev_err_ff;
         best_a_in   = ev_a_ff;
         best_b_in   = ev_b_ff;
      end

      unique case (state_ff)
         S_LOAD: begin
            if (store) begin
               count_in = count_ff + 1'b1;
               if (in_sample.label) tot_t_in = tot_t_ff + SW'(req_sample_weight);
               else tot_f_in = tot_f_ff + SW'(req_sample_weight);
            end else if (accept) begin
               ovf_in = 1'b1;
            end
            if (accept && req_last_sample) begin
               state_in = S_SETTLE;
               cnt_in   = '0;
            end
         end
         S_SETTLE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == count_ff) begin
               state_in  = S_DRAIN;
               cnt_in    = '0;
               bt_in     = '0;
               bf_in     = '0;
               best_v_in = 1'b0;
            end
         end
         S_DRAIN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '0) begin
               single_in = {e.feature, 1'b0};
               gdup_in   = 1'b0;
            end else if (e.feature == pf_ff) begin
               gdup_in = 1'b1;
            end else begin
               // close the previous equal-feature group
               cand_v_in = 1'b1;
               cand_s_in = gdup_ff ? {pf_ff, 1'b0}
                                   : {pf_ff[31], pf_ff} + {e.feature[31], e.feature};
               gdup_in = 1'b0;
            end
            pf_in = e.feature;
            if (e.label) bt_in = bt_ff + SW'(e.weight);
            else bf_in = bf_ff + SW'(e.weight);
            if (cnt_ff == count_ff - 1'b1) state_in = S_FINAL;
         end
         S_FINAL: begin
            cand_v_in = gdup_ff;
            cand_s_in = {pf_ff, 1'b0};
            cnt_in    = '0;
            state_in  = S_FLUSH;
         end
         S_FLUSH: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(1)) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rv_ff || rsp_ready) begin
               rv_in   = 1'b1;
               o_ns_in = !best_v_ff;
               o_ov_in = ovf_ff;
               o_s_in  = best_v_ff ? best_s_ff : single_ff;
               o_a_in  = best_v_ff ? best_a_ff : 1'b1;
               o_b_in  = best_v_ff && best_b_ff;
               o_e_in  = (!best_v_ff || err_wide > SW'(ERR_MAX)) ? ERR_MAX
                                                                 : err_wide[ERR_W-1:0];
               count_in = '0;
               ovf_in   = 1'b0;
               tot_t_in = '0;
               tot_f_in = '0;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         count_ff  <= '0;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         tot_t_ff  <= '0;
         tot_f_ff  <= '0;
         cand_v_ff <= 1'b0;
         ev_v_ff   <= 1'b0;
         best_v_ff <= 1'b0;
         rv_ff     <= 1'b0;
         gdup_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         tot_t_ff  <= tot_t_in;
         tot_f_ff  <= tot_f_in;
         cand_v_ff <= cand_v_in;
         ev_v_ff   <= cand_v_ff;
         best_v_ff <= best_v_in;
         rv_ff     <= rv_in;
         gdup_ff   <= gdup_in;
      end
   end

   always_ff @(posedge clock) begin
      pf_ff       <= pf_in;
      bt_ff       <= bt_in;
      bf_ff       <= bf_in;
      single_ff   <= single_in;
      cand_s_ff   <= cand_s_in;
      cand_bt_ff  <= cand_bt_in;
      cand_bf_ff  <= cand_bf_in;
      ev_s_ff     <= cand_s_ff;
      ev_err_ff   <= ev_err_in;
      ev_a_ff     <= ev_a_in;
      ev_b_ff     <= ev_b_in;
      best_s_ff   <= best_s_in;
      best_err_ff <= best_err_in;
      best_a_ff   <= best_a_in;
      best_b_ff   <= best_b_in;
      o_s_ff      <= o_s_in;
      o_a_ff      <= o_a_in;
      o_b_ff      <= o_b_in;
      o_e_ff      <= o_e_in;
      o_ns_ff     <= o_ns_in;
      o_ov_ff     <= o_ov_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_split_twice    = o_s_ff;
   assign rsp_above_result   = o_a_ff;
   assign rsp_below_result   = o_b_ff;
   assign rsp_weighted_error = o_e_ff;
   assign rsp_no_split       = o_ns_ff;
   assign rsp_overflow       = o_ov_ff;

endmodule

/* hdl/wdst_checker.sv */
// ----------------------------------------------------------------------------
// wdst_checker
// Port-level checks of the stump trainer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wdst_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [32:0] rsp_split_twice,
   input logic               rsp_above_result,
   input logic               rsp_below_result,
   input logic [25:0]        rsp_weighted_error,
   input logic               rsp_no_split
);

   `WDST_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_split_twice))
   `WDST_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_weighted_error))
   `WDST_ASSERT(a_nosplit_err, rsp_valid && rsp_no_split |-> &rsp_weighted_error)
   `WDST_ASSERT(a_nosplit_lbl, rsp_valid && rsp_no_split |-> rsp_above_result && !rsp_below_result)
   `WDST_ASSERT_ALWAYS(a_reset, reset |=> !rsp_valid)

endmodule

bind weighted_decision_stump_trainer wdst_checker u_wdst_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_split_twice    (rsp_split_twice),
   .rsp_above_result   (rsp_above_result),
   .rsp_below_result   (rsp_below_result),
   .rsp_weighted_error (rsp_weighted_error),
   .rsp_no_split       (rsp_no_split)
);
